// ===== rtl/core/ds_twr_ranging_responder_assert.svh =====
// Assertion macros for the ranging responder.
// Each check is sampled on the rising edge of clk and is disabled during rst.
`ifndef DS_TWR_RANGING_RESPONDER_ASSERT_SVH
`define DS_TWR_RANGING_RESPONDER_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold at every edge.
`define DSTWR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ds_twr_ranging_responder: check failed");

// Same-cycle implication.
`define DSTWR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ds_twr_ranging_responder: implication failed");

// Next-cycle implication.
`define DSTWR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ds_twr_ranging_responder: next-cycle check failed");

`else

`define DSTWR_ASSERT(lbl, prop)
`define DSTWR_ASSERT_IMPLY(lbl, ante, cons)
`define DSTWR_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/dstwr_pkg.sv =====
`timescale 1ns / 1ps

package dstwr_pkg;

  // Field widths
  localparam int REQ_W     = 2;
  localparam int LEN_W     = 7;
  localparam int HDR_LO_W  = 64;
  localparam int HDR_HI_W  = 16;
  localparam int STAMP_W   = 40;
  localparam int TICK_W    = 32;
  localparam int ACT_W     = 2;
  localparam int SEQ_W     = 8;
  localparam int PROD_W    = 2 * TICK_W;
  localparam int DEN_W     = TICK_W + 2;

  // Frame format
  localparam int HEADER_BYTES    = 10;
  localparam int MAX_FRAME_BYTES = 24;

  localparam logic [HDR_LO_W-1:0] HDR_LOW_MASK   = 64'hFFFF_FFFF_FF00_FFFF;
  localparam logic [HDR_LO_W-1:0] HDR_LOW_EXPECT = 64'h5641_57DE_CA00_8841;
  localparam logic [HDR_HI_W-1:0] HDR_HIGH_POLL  = 16'h2145;
  localparam logic [HDR_HI_W-1:0] HDR_HIGH_FINAL = 16'h2345;

  // Reply delay after reset: 900 us in device time units
  localparam logic [STAMP_W-1:0] DELAY_RESET = STAMP_W'(900 * 63898);

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS = PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic signed [TICK_W-1:0] FLIGHT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [TICK_W-1:0] FLIGHT_MIN = 32'sh8000_0000;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_GOOD      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RX_ERROR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TX_REJECT = 2'd2;

  // Result action codes
  localparam logic [ACT_W-1:0] ACT_LISTEN = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEND   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RANGE  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load_idle;
    logic load_poll;
    logic load_final;
    logic seq_inc;
    logic mul_p;
    logic mul_q;
    logic diff;
    logic div_step;
    logic finish;
    logic push;
  } dstwr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_good;
    logic req_reject;
    logic poll_match;
    logic final_match;
  } dstwr_sts_t;

endpackage

// ===== rtl/core/dstwr_if.sv =====
`timescale 1ns / 1ps

// Request channel: one received frame event per item
interface dstwr_req_if;
  logic                              valid;
  logic                              ready;
  logic [dstwr_pkg::REQ_W-1:0]       req_type;
  logic [dstwr_pkg::LEN_W-1:0]       frame_length;
  logic [dstwr_pkg::HDR_LO_W-1:0]    header_low;
  logic [dstwr_pkg::HDR_HI_W-1:0]    header_high;
  logic [dstwr_pkg::STAMP_W-1:0]     rx_stamp;
  logic [dstwr_pkg::STAMP_W-1:0]     response_tx_stamp;
  logic [dstwr_pkg::TICK_W-1:0]      initiator_poll_tx;
  logic [dstwr_pkg::TICK_W-1:0]      initiator_resp_rx;
  logic [dstwr_pkg::TICK_W-1:0]      initiator_final_tx;

  modport source (
    output valid, req_type, frame_length, header_low, header_high, rx_stamp,
           response_tx_stamp, initiator_poll_tx, initiator_resp_rx, initiator_final_tx,
    input  ready
  );
  modport sink (
    input  valid, req_type, frame_length, header_low, header_high, rx_stamp,
           response_tx_stamp, initiator_poll_tx, initiator_resp_rx, initiator_final_tx,
    output ready
  );
endinterface

// Result channel: one item per request item
interface dstwr_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [dstwr_pkg::ACT_W-1:0]        action;
  logic [dstwr_pkg::TICK_W-1:0]       send_time;
  logic [dstwr_pkg::SEQ_W-1:0]        sequence_number;
  logic signed [dstwr_pkg::TICK_W-1:0] flight_ticks;

  modport source (
    output valid, action, send_time, sequence_number, flight_ticks,
    input  ready
  );
  modport sink (
    input  valid, action, send_time, sequence_number, flight_ticks,
    output ready
  );
endinterface

// Configuration write channel: reply delay register
interface dstwr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dstwr_pkg::STAMP_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/core/dstwr_datapath.sv =====
`timescale 1ns / 1ps

module dstwr_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dstwr_pkg::dstwr_cmd_t                cmd,
  output dstwr_pkg::dstwr_sts_t                sts,
  // request payload
  input  logic [dstwr_pkg::REQ_W-1:0]          req_type,
  input  logic [dstwr_pkg::LEN_W-1:0]          frame_length,
  input  logic [dstwr_pkg::HDR_LO_W-1:0]       header_low,
  input  logic [dstwr_pkg::HDR_HI_W-1:0]       header_high,
  input  logic [dstwr_pkg::STAMP_W-1:0]        rx_stamp,
  input  logic [dstwr_pkg::STAMP_W-1:0]        response_tx_stamp,
  input  logic [dstwr_pkg::TICK_W-1:0]         initiator_poll_tx,
  input  logic [dstwr_pkg::TICK_W-1:0]         initiator_resp_rx,
  input  logic [dstwr_pkg::TICK_W-1:0]         initiator_final_tx,
  // configuration write
  input  logic                                 cfg_valid,
  input  logic [dstwr_pkg::STAMP_W-1:0]        cfg_data,
  // result payload
  output logic [dstwr_pkg::ACT_W-1:0]          action,
  output logic [dstwr_pkg::TICK_W-1:0]         send_time,
  output logic [dstwr_pkg::SEQ_W-1:0]          sequence_number,
  output logic signed [dstwr_pkg::TICK_W-1:0]  flight_ticks
);

  localparam int TW = dstwr_pkg::TICK_W;
  localparam int PW = dstwr_pkg::PROD_W;
  localparam int DW = dstwr_pkg::DEN_W;
  localparam int SW = dstwr_pkg::STAMP_W;

  // State kept across frames
  logic [SW-1:0]                    reply_delay;
  logic [dstwr_pkg::SEQ_W-1:0]      seq_counter;
  logic [TW-1:0]                    poll_rx_low;

  // Working registers
  logic [TW-1:0]                    ra, rb, da, db;
  logic [PW-1:0]                    prod_p, prod_q;
  logic [DW-1:0]                    den;
  logic                             neg;
  logic [DW-1:0]                    rem;
  logic [PW-1:0]                    quo;

  // Pending result
  logic [dstwr_pkg::ACT_W-1:0]      res_action;
  logic [TW-1:0]                    res_send_time;
  logic [dstwr_pkg::SEQ_W-1:0]      res_seq;
  logic signed [TW-1:0]             res_flight;

  logic                             len_ok, low_ok;
  logic [SW:0]                      send_sum;
  logic [TW-1:0]                    mul_a, mul_b;
  logic [PW-1:0]                    mul_out;
  logic [DW:0]                      div_rs, div_diff;
  logic                             div_ge;
  logic                             quo_fits;

  // Header decode
  assign len_ok = (frame_length >= dstwr_pkg::LEN_W'(dstwr_pkg::HEADER_BYTES)) &&
                  (frame_length <= dstwr_pkg::LEN_W'(dstwr_pkg::MAX_FRAME_BYTES));
  assign low_ok = (header_low & dstwr_pkg::HDR_LOW_MASK) == dstwr_pkg::HDR_LOW_EXPECT;

  assign sts.req_good    = (req_type == dstwr_pkg::REQ_GOOD);
  assign sts.req_reject  = (req_type == dstwr_pkg::REQ_TX_REJECT);
  assign sts.poll_match  = len_ok && low_ok && (header_high == dstwr_pkg::HDR_HIGH_POLL);
  assign sts.final_match = len_ok && low_ok && (header_high == dstwr_pkg::HDR_HIGH_FINAL);

  // Delayed send time: bits 39:8 of the 41-bit sum
  assign send_sum = {1'b0, rx_stamp} + {1'b0, reply_delay};

  // Shared multiplier
  assign mul_a   = cmd.mul_q ? da : ra;
  assign mul_b   = cmd.mul_q ? db : rb;
  assign mul_out = PW'(mul_a) * PW'(mul_b);

  // Restoring divider step
  assign div_rs   = {rem, quo[PW-1]};
  assign div_ge   = div_rs >= {1'b0, den};
  assign div_diff = div_rs - {1'b0, den};

  // Quotient fits the signed range check (upper bits all zero)
  assign quo_fits = (quo[PW-1:TW-1] == '0);

  // Configuration and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_delay <= dstwr_pkg::DELAY_RESET;
      seq_counter <= '0;
      poll_rx_low <= '0;
    end else begin
      if (cfg_valid) begin
        reply_delay <= cfg_data;
      end
      if (cmd.seq_inc) begin
        seq_counter <= seq_counter + 1'b1;
      end
      if (cmd.load_poll) begin
        poll_rx_low <= rx_stamp[TW-1:0];
      end
    end
  end

  // Intervals, products, divider
  always_ff @(posedge clk) begin
    if (cmd.load_final) begin
      ra <= initiator_resp_rx - initiator_poll_tx;
      rb <= rx_stamp[TW-1:0] - response_tx_stamp[TW-1:0];
      da <= initiator_final_tx - initiator_resp_rx;
      db <= response_tx_stamp[TW-1:0] - poll_rx_low;
    end
    if (cmd.mul_p) begin
      prod_p <= mul_out;
      den    <= DW'(ra) + DW'(rb) + DW'(da) + DW'(db);
    end
    if (cmd.mul_q) begin
      prod_q <= mul_out;
    end
    if (cmd.diff) begin
      neg <= prod_p < prod_q;
      quo <= (prod_p < prod_q) ? (prod_q - prod_p) : (prod_p - prod_q);
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= div_ge ? div_diff[DW-1:0] : div_rs[DW-1:0];
      quo <= {quo[PW-2:0], div_ge};
    end
  end

  // Pending result register
  always_ff @(posedge clk) begin
    if (cmd.load_idle) begin
      res_action    <= dstwr_pkg::ACT_LISTEN;
      res_send_time <= '0;
      res_seq       <= '0;
      res_flight    <= '0;
    end
    if (cmd.load_poll) begin
      res_action    <= dstwr_pkg::ACT_SEND;
      res_send_time <= send_sum[SW-1:SW-TW];
      res_seq       <= seq_counter;
      res_flight    <= '0;
    end
    if (cmd.load_final) begin
      res_action    <= dstwr_pkg::ACT_RANGE;
      res_send_time <= '0;
      res_seq       <= '0;
    end
    if (cmd.finish) begin
      if (den == '0) begin
        res_flight <= '0;
      end else if (!neg) begin
        res_flight <= quo_fits ? $signed(quo[TW-1:0]) : dstwr_pkg::FLIGHT_MAX;
      end else begin
        res_flight <= quo_fits ? $signed(-quo[TW-1:0]) : dstwr_pkg::FLIGHT_MIN;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      action          <= res_action;
      send_time       <= res_send_time;
      sequence_number <= res_seq;
      flight_ticks    <= res_flight;
    end
  end

endmodule

// ===== rtl/core/dstwr_ctrl.sv =====
`timescale 1ns / 1ps

module dstwr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  dstwr_pkg::dstwr_sts_t  sts,
  output dstwr_pkg::dstwr_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL_P = 7'b0000010,
    ST_MUL_Q = 7'b0000100,
    ST_DIFF  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_FIN   = 7'b0100000,
    ST_PUSH  = 7'b1000000
  } state_t;

  state_t                          state, state_next;
  logic                            awaiting_final, awaiting_final_next;
  logic [dstwr_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                            accept;
  logic                            slot_free;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;

  // Next state and commands
  always_comb begin
    state_next          = state;
    awaiting_final_next = awaiting_final;
    cmd                 = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PUSH;
          if (!awaiting_final) begin
            if (sts.req_good && sts.poll_match) begin
              cmd.load_poll       = 1'b1;
              awaiting_final_next = 1'b1;
            end else begin
              cmd.load_idle = 1'b1;
            end
          end else begin
            awaiting_final_next = 1'b0;
            cmd.seq_inc         = !sts.req_reject;
            if (sts.req_good && sts.final_match) begin
              cmd.load_final = 1'b1;
              state_next     = ST_MUL_P;
            end else begin
              cmd.load_idle = 1'b1;
            end
          end
        end
      end
      ST_MUL_P: begin
        cmd.mul_p  = 1'b1;
        state_next = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        cmd.mul_q  = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == dstwr_pkg::DIV_CNT_W'(dstwr_pkg::DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      awaiting_final <= 1'b0;
      div_cnt        <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      awaiting_final <= awaiting_final_next;
      if (cmd.diff) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/ds_twr_ranging_responder.sv =====
`timescale 1ns / 1ps
`include "ds_twr_ranging_responder_assert.svh"

// Responder side of double-sided two-way ranging.
// req: one item per radio event (good frame, receive error, send rejected).
// rsp: exactly one item per request item: restart listening, send the
//   response at send_time with sequence_number, or a signed time of flight.
// cfg: writes the 40-bit reply delay; always ready, take effect next cycle.
// A non-final item goes from the idle state straight to the push state.
// A matching final frame runs four setup steps on the shared 32x32
// multiplier and interval adders, then a restoring divider producing
// one quotient bit per cycle over the 64-bit quotient, then saturation.
// One item is processed at a time; req.ready is high while the sequencer
// is idle. A result sits in an output register, so the next item is taken
// while rsp is stalled; its own result then waits until the output is free.
// Reset clears the phase (listening), the sequence counter, the stored poll
// stamp and any pending output, and loads the default reply delay.
module ds_twr_ranging_responder (
  input  logic        clk,
  input  logic        rst,
  dstwr_req_if.sink   req,
  dstwr_rsp_if.source rsp,
  dstwr_cfg_if.sink   cfg
);

  dstwr_pkg::dstwr_cmd_t cmd;
  dstwr_pkg::dstwr_sts_t sts;
  logic                  req_ready;
  logic                  rsp_valid;
  logic [8:0]            cmd_steps;

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign cfg.ready = 1'b1;

  // Sequencer
  dstwr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Decode, arithmetic and result registers
  dstwr_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .req_type           (req.req_type),
    .frame_length       (req.frame_length),
    .header_low         (req.header_low),
    .header_high        (req.header_high),
    .rx_stamp           (req.rx_stamp),
    .response_tx_stamp  (req.response_tx_stamp),
    .initiator_poll_tx  (req.initiator_poll_tx),
    .initiator_resp_rx  (req.initiator_resp_rx),
    .initiator_final_tx (req.initiator_final_tx),
    .cfg_valid          (cfg.valid),
    .cfg_data           (cfg.data),
    .action             (rsp.action),
    .send_time          (rsp.send_time),
    .sequence_number    (rsp.sequence_number),
    .flight_ticks       (rsp.flight_ticks)
  );

  // Sequencing commands, at most one per cycle
  assign cmd_steps = {cmd.load_idle, cmd.load_poll, cmd.load_final, cmd.mul_p, cmd.mul_q,
                      cmd.diff, cmd.div_step, cmd.finish, cmd.push};

  // Checks
  `DSTWR_ASSERT(a_single_step, $onehot0(cmd_steps))
  `DSTWR_ASSERT_IMPLY(a_push_needs_slot, cmd.push, !rsp_valid || rsp.ready)
  `DSTWR_ASSERT_NEXT(a_busy_after_accept, req.valid && req_ready, !req_ready)
  `DSTWR_ASSERT_IMPLY(a_seq_inc_on_accept, cmd.seq_inc, cmd.load_final || cmd.load_idle)

endmodule
